FILE: sv/pip_pkg.sv
// Shared types, constants and op codes of the point-in-polygon test core.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 32;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int TOL_W        = 8;
    localparam int PROD_W       = 2 * COORD_W;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        mag_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } pip_in_t;

    typedef struct packed {
        logic is_inside;
        logic polygon_empty;
        logic vertices_dropped;
    } pip_out_t;

    // controller to datapath
    typedef struct packed {
        logic             do_clear;
        logic             do_append;
        logic             do_query;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             rd_edge;
        logic             rd_near;
        logic             out_load;
    } pip_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
        logic             out_free;
    } pip_stat_t;

endpackage

FILE: sv/pip_datapath.sv
// Datapath: vertex tables, query pipeline, flags and result register.
module pip_datapath
    import pip_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  pip_in_t          in_data,
    input  pip_cmd_t         cmd,
    output pip_stat_t        stat,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pip_out_t         m_data
);

    // unsigned distance between two signed coordinates, as compare and select
    function automatic mag_t abs_diff(input coord_t a, input coord_t b);
        mag_t d1;
        mag_t d2;
        d1 = $unsigned(a) - $unsigned(b);
        d2 = $unsigned(b) - $unsigned(a);
        return (a < b) ? d2 : d1;
    endfunction

    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [TOL_W-1:0] tol_reg;
    logic             full;

    coord_t qx_reg, qy_reg;

    // read stage
    coord_t rd_x_reg, rd_y_reg;
    logic   rd_v_reg, rd_edge_reg, rd_near_reg;
    coord_t pvx_reg, pvy_reg;

    // stage A: magnitudes and signs
    logic   va_reg, va_cross_reg, va_near_reg;
    mag_t   dxm_reg, mm_reg, bm_reg, exm_reg;
    logic   dxn_reg, bn_reg, exn_reg;
    logic [TOL_W-1:0] axs_reg, ays_reg;

    // stage B: products
    logic              vb_reg, vb_cross_reg, vb_near_reg;
    logic [PROD_W-1:0] pm_reg, qm_reg;
    logic              pn_reg, qn_reg;

    logic near_acc_reg, odd_acc_reg;

    logic     m_valid_reg;
    pip_out_t out_reg;

    assign full = (count_reg == CNT_W'(MAX_VERTICES));

    // vertex count and sticky overflow
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.do_clear) begin
            count_next = '0;
        end else if (cmd.do_append) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            tol_reg   <= TOL_W'(1);
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
        end
    end

    // write vertex tables
    always_ff @(posedge aclk) begin
        if (cmd.do_append && !full) begin
            mem_x[count_reg[IDX_W-1:0]] <= in_data.x_coord;
            mem_y[count_reg[IDX_W-1:0]] <= in_data.y_coord;
        end
    end

    // read vertex tables
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_x_reg <= mem_x[cmd.rd_addr];
            rd_y_reg <= mem_y[cmd.rd_addr];
        end
    end

    // hold query point
    always_ff @(posedge aclk) begin
        if (cmd.do_query) begin
            qx_reg <= in_data.x_coord;
            qy_reg <= in_data.y_coord;
        end
    end

    // stage A combinational terms
    logic   up, down;
    mag_t   ax, ay;
    logic   ax_lt, ay_lt;

    always_comb begin
        up    = (pvy_reg <= qy_reg) && (rd_y_reg > qy_reg);
        down  = (pvy_reg > qy_reg) && (rd_y_reg <= qy_reg);
        ax    = abs_diff(qx_reg, rd_x_reg);
        ay    = abs_diff(qy_reg, rd_y_reg);
        ax_lt = ax < mag_t'(tol_reg);
        ay_lt = ay < mag_t'(tol_reg);
    end

    // stage C compare: (x - px) * |ey| < b * (cx - px), sign corrected
    logic pne, qne, less;

    always_comb begin
        pne = pn_reg && (pm_reg != '0);
        qne = qn_reg && (qm_reg != '0);
        if (pne != qne) begin
            less = pne;
        end else if (pne) begin
            less = pm_reg > qm_reg;
        end else begin
            less = pm_reg < qm_reg;
        end
    end

    logic [2*TOL_W:0]   sq_sum;
    logic [2*TOL_W-1:0] tol_sq;

    assign sq_sum = (2*TOL_W+1)'(axs_reg * axs_reg) + (2*TOL_W+1)'(ays_reg * ays_reg);
    assign tol_sq = tol_reg * tol_reg;

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
        end else begin
            rd_v_reg <= cmd.rd_en;
            va_reg   <= rd_v_reg;
            vb_reg   <= va_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_edge_reg <= cmd.rd_edge;
            rd_near_reg <= cmd.rd_near;
        end
        if (rd_v_reg) begin
            pvx_reg      <= rd_x_reg;
            pvy_reg      <= rd_y_reg;
            va_cross_reg <= rd_edge_reg && (up || down);
            va_near_reg  <= rd_near_reg && ax_lt && ay_lt;
            dxm_reg      <= abs_diff(qx_reg, pvx_reg);
            dxn_reg      <= qx_reg < pvx_reg;
            mm_reg       <= abs_diff(rd_y_reg, pvy_reg);
            bm_reg       <= abs_diff(qy_reg, pvy_reg);
            bn_reg       <= (qy_reg < pvy_reg) ^ (rd_y_reg < pvy_reg);
            exm_reg      <= abs_diff(rd_x_reg, pvx_reg);
            exn_reg      <= rd_x_reg < pvx_reg;
            axs_reg      <= ax[TOL_W-1:0];
            ays_reg      <= ay[TOL_W-1:0];
        end
        if (va_reg) begin
            vb_cross_reg <= va_cross_reg;
            vb_near_reg  <= va_near_reg && (sq_sum < (2*TOL_W+1)'(tol_sq));
            pm_reg       <= dxm_reg * mm_reg;
            qm_reg       <= bm_reg * exm_reg;
            pn_reg       <= dxn_reg;
            qn_reg       <= bn_reg ^ exn_reg;
        end
    end

    // accumulate proximity hits and crossing parity
    always_ff @(posedge aclk) begin
        if (cmd.do_query) begin
            near_acc_reg <= 1'b0;
            odd_acc_reg  <= 1'b0;
        end else if (vb_reg) begin
            if (vb_near_reg) begin
                near_acc_reg <= 1'b1;
            end
            if (vb_cross_reg && less) begin
                odd_acc_reg <= !odd_acc_reg;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.is_inside        <= (count_reg != '0) && (near_acc_reg || odd_acc_reg);
            out_reg.polygon_empty    <= (count_reg == '0);
            out_reg.vertices_dropped <= ovf_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = out_reg;
    assign stat.count    = count_reg;
    assign stat.busy     = rd_v_reg || va_reg || vb_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

FILE: sv/pip_ctrl.sv
// Controller: input decode and the vertex read sequence of a query.
module pip_ctrl
    import pip_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [1:0] op,
    input  pip_stat_t stat,
    output pip_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             first_reg, first_next;
    logic [IDX_W-1:0] last_idx;

    assign last_idx = IDX_W'(stat.count - 1'b1);
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        first_next = first_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (op)
                        OP_CLEAR:  cmd.do_clear  = 1'b1;
                        OP_APPEND: cmd.do_append = 1'b1;
                        OP_QUERY: begin
                            cmd.do_query = 1'b1;
                            idx_next     = '0;
                            first_next   = 1'b1;
                            state_next   = (stat.count == '0) ? ST_DONE : ST_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                // read the closing vertex first, then walk the table
                cmd.rd_en = 1'b1;
                if (first_reg) begin
                    cmd.rd_addr = last_idx;
                    first_next  = 1'b0;
                end else begin
                    cmd.rd_addr = idx_reg;
                    cmd.rd_edge = 1'b1;
                    cmd.rd_near = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    if (idx_reg == last_idx) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            first_reg <= first_next;
        end
    end

endmodule

FILE: sv/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test core.
//
// Input channel s_*: one beat carries op, x_coord, y_coord (signed Q16.16).
// Clear and append beats are accepted while idle and give no result;
// an append to a full table (64 vertices) is dropped and sets a sticky
// overflow flag that only reset clears. Unused op codes are ignored.
// A query beat gives one result beat on m_*: is_inside, polygon_empty and
// vertices_dropped. A query on n vertices runs n + 1 table reads through
// the single read port (closing vertex first), a three-stage pipeline of
// magnitudes, 32x32 products and compare, then the result register load.
// An empty polygon skips the reads and goes straight to the result load.
// While a query runs s_ready is low. A finished result waits in the output
// register while the next beat is accepted; if m_ready stays low a new
// query completes its walk and holds until the register frees.
// cfg_wr_en / cfg_wr_data write vertex_tolerance (reset 1); the user
// must do so only when idle, which the block itself does not enforce.
// Synchronous active-low reset empties the polygon and clears the flags.
module point_in_polygon_test_core
    import pip_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pip_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pip_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [TOL_W-1:0] cfg_wr_data
);

    pip_cmd_t  cmd;
    pip_stat_t stat;

    pip_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_data.op),
        .stat    (stat),
        .cmd     (cmd)
    );

    pip_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_data     (s_data),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: tb/point_in_polygon_test_core_tb.sv
// Testbench for point_in_polygon_test_core: random polygons and point queries checked beat by beat.
module point_in_polygon_test_core_tb
    import pip_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Running copy of the vertex table, the flags and the tolerance; holds the
    // answers that queries already accepted by the core must produce.
    class polygon_tracker;
        longint          vert_x[MAX_VERTICES];
        longint          vert_y[MAX_VERTICES];
        int unsigned     vert_count;
        bit              dropped_flag;
        bit [TOL_W-1:0]  tolerance;
        pip_out_t        answers[$];
        int              errors;

        function new();
            vert_count   = 0;
            dropped_flag = 1'b0;
            tolerance    = 1;
            errors       = 0;
        endfunction

        function longint unsigned abs_of(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        // a*b < c*d, exact over 64-bit magnitudes
        function bit product_below(longint a, longint b, longint c, longint d);
            longint unsigned pm, qm;
            bit pn, qn;
            pm = abs_of(a) * abs_of(b);
            qm = abs_of(c) * abs_of(d);
            pn = (pm != 0) && ((a < 0) != (b < 0));
            qn = (qm != 0) && ((c < 0) != (d < 0));
            if (pn != qn)
                return pn;
            if (pn)
                return pm > qm;
            return pm < qm;
        endfunction

        function bit near_any_vertex(longint x, longint y);
            longint unsigned tol, ax, ay;
            int unsigned i;
            tol = tolerance;
            for (i = 0; i < vert_count; i++) begin
                ax = abs_of(x - vert_x[i]);
                ay = abs_of(y - vert_y[i]);
                if (ax < tol && ay < tol && ax * ax + ay * ay < tol * tol)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        // parity of edges crossing the ray to the right, closing edge included
        function bit odd_edge_crossings(longint x, longint y);
            int unsigned prev, i;
            longint px, py, cx, cy, ey, ry, m, b;
            bit odd;
            prev = vert_count - 1;
            odd  = 1'b0;
            for (i = 0; i < vert_count; i++) begin
                px = vert_x[prev];
                py = vert_y[prev];
                cx = vert_x[i];
                cy = vert_y[i];
                if ((py <= y && cy > y) || (py > y && cy <= y)) begin
                    ey = cy - py;
                    ry = y - py;
                    m  = (ey < 0) ? -ey : ey;
                    b  = (ey < 0) ? -ry : ry;
                    if (product_below(x - px, m, b, cx - px))
                        odd = !odd;
                end
                prev = i;
            end
            return odd;
        endfunction

        // Update the table for one accepted input beat; queue the answer of a query.
        function void note_beat(pip_in_t beat);
            coord_t   cx, cy;
            longint   x, y;
            pip_out_t ans;
            cx = beat.x_coord;
            cy = beat.y_coord;
            x  = cx;
            y  = cy;
            case (beat.op)
                OP_CLEAR: begin
                    vert_count = 0;
                end
                OP_APPEND: begin
                    if (vert_count < MAX_VERTICES) begin
                        vert_x[vert_count] = x;
                        vert_y[vert_count] = y;
                        vert_count++;
                    end else begin
                        dropped_flag = 1'b1;
                    end
                end
                OP_QUERY: begin
                    ans.polygon_empty    = (vert_count == 0);
                    ans.is_inside        = (vert_count != 0) &&
                                           (near_any_vertex(x, y) || odd_edge_crossings(x, y));
                    ans.vertices_dropped = dropped_flag;
                    answers.push_back(ans);
                end
                default: ;
            endcase
        endfunction

        function void compare_bit(string field, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_answer(pip_out_t got);
            pip_out_t want;
            if (answers.size() == 0) begin
                $display("%0t: result beat with no query pending, expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = answers.pop_front();
            compare_bit("is_inside", want.is_inside, got.is_inside);
            compare_bit("polygon_empty", want.polygon_empty, got.polygon_empty);
            compare_bit("vertices_dropped", want.vertices_dropped, got.vertices_dropped);
        endfunction
    endclass

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    pip_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    pip_out_t         m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [TOL_W-1:0] cfg_wr_data = '0;

    polygon_tracker tracker = new();
    int beats_sent  = 0;
    int calm_sends  = 0;

    point_in_polygon_test_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hang guard.
    initial begin
        #20_000_000;
        $display("point_in_polygon_test_core_tb: done, errors");
        $finish;
    end

    // Result side: check each beat, stall at random, hold off long twice.
    initial begin : result_sink
        int hold, calm, taken, r;
        hold  = 0;
        calm  = 0;
        taken = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                tracker.check_answer(m_data);
                taken++;
                if (taken == 40 || taken == 300)
                    hold = 400;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if (calm > 0) begin
                m_ready <= 1'b1;
                calm--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm = $urandom_range(20, 80);
                else if (r < 7)
                    hold = $urandom_range(8, 40);
                m_ready <= (r < 70);
            end
        end
    end

    // Gap before the next input beat: mostly none, sometimes short, rarely long.
    function automatic int sender_gap();
        int r;
        if (calm_sends > 0) begin
            calm_sends--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            calm_sends = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random coordinate in +/- 2^span, or any 32-bit value for span 32.
    function automatic logic [31:0] pick_coord(int span);
        longint lim;
        if (span >= 32)
            return $urandom;
        lim = longint'(1) << span;
        return 32'(longint'($urandom_range(0, 32'(2 * lim - 1))) - lim);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y);
        pip_in_t beat;
        int      idle;
        beat.op      = op;
        beat.x_coord = x;
        beat.y_coord = y;
        idle = sender_gap();
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        tracker.note_beat(beat);
        beats_sent++;
    endtask

    // Write the tolerance once the core has drained and gone quiet.
    task automatic set_tolerance(input logic [TOL_W-1:0] tol);
        s_valid <= 1'b0;
        while (tracker.answers.size() != 0) @(posedge aclk);
        repeat (MAX_VERTICES + 16) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tol;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.tolerance = tol;
    endtask

    // Build one polygon, then query points on, near and around it.
    task automatic run_polygon(int n, int span, int queries);
        logic [31:0] px[$], py[$];
        logic [31:0] x, y;
        int k, pick, idx, tol;
        if ($urandom_range(0, 9) != 0 || tracker.vert_count + n > MAX_VERTICES)
            send_beat(OP_CLEAR, pick_coord(32), pick_coord(32));
        for (k = 0; k < n; k++) begin
            x = pick_coord(span);
            y = pick_coord(span);
            if (k > 0 && $urandom_range(0, 3) == 0)
                y = py[k-1];
            else if (k > 0 && $urandom_range(0, 5) == 0)
                x = px[k-1];
            px.push_back(x);
            py.push_back(y);
            send_beat(OP_APPEND, x, y);
            if ($urandom_range(0, 29) == 0)
                send_beat(OP_UNUSED, pick_coord(32), pick_coord(32));
        end
        for (k = 0; k < queries; k++) begin
            pick = $urandom_range(0, 99);
            tol  = tracker.tolerance;
            x    = pick_coord(span);
            y    = pick_coord(span);
            if (n > 0) begin
                idx = $urandom_range(0, n - 1);
                if (pick < 20) begin
                    y = py[idx];
                end else if (pick < 35) begin
                    x = px[idx] + ($urandom_range(0, 2 * tol + 4) - (tol + 2));
                    y = py[idx] + ($urandom_range(0, 2 * tol + 4) - (tol + 2));
                end else if (pick < 42) begin
                    x = px[idx];
                    y = py[idx];
                end else if (pick < 50) begin
                    x = pick_coord(32);
                    y = pick_coord(32);
                end
            end
            send_beat(OP_QUERY, x, y);
            if ($urandom_range(0, 29) == 0)
                send_beat(OP_UNUSED, pick_coord(32), pick_coord(32));
        end
    endtask

    task automatic random_phase(int target);
        int stop_at, n, r, span;
        stop_at = beats_sent + target;
        while (beats_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                n = 0;
            else if (r < 85)
                n = $urandom_range(1, 8);
            else if (r < 97)
                n = $urandom_range(9, 24);
            else
                n = MAX_VERTICES;
            case ($urandom_range(0, 3))
                0:       span = 6;
                1:       span = 12;
                2:       span = 22;
                default: span = 32;
            endcase
            run_polygon(n, span, $urandom_range(2, 8));
        end
    endtask

    // Main sequence: reset, directed cases, random phases per tolerance, overflow.
    initial begin : stimulus
        logic [TOL_W-1:0] tol_plan[6];
        int k;
        tol_plan = '{8'd255, 8'd3, 8'd0, 8'd77, 8'd1, 8'd200};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty polygon, ignored op, single vertex at reset tolerance
        send_beat(OP_QUERY, 0, 0);
        send_beat(OP_UNUSED, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(OP_APPEND, 10, 10);
        send_beat(OP_QUERY, 10, 10);
        send_beat(OP_QUERY, 11, 10);

        // square with horizontal edges; points on edge and vertex heights
        send_beat(OP_CLEAR, 0, 0);
        send_beat(OP_APPEND, 0, 0);
        send_beat(OP_APPEND, 100, 0);
        send_beat(OP_APPEND, 100, 100);
        send_beat(OP_APPEND, 0, 100);
        send_beat(OP_QUERY, 50, 50);
        send_beat(OP_QUERY, 50, 0);
        send_beat(OP_QUERY, 150, 50);
        send_beat(OP_QUERY, -50, 100);
        send_beat(OP_QUERY, 100, 50);
        send_beat(OP_QUERY, -1, 0);

        // triangle spanning the full coordinate range
        send_beat(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_APPEND, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(OP_APPEND, 0, 32'h7fff_ffff);
        send_beat(OP_QUERY, 0, 0);
        send_beat(OP_QUERY, 32'h7fff_ffff, 32'h7fff_ffff);
        send_beat(OP_QUERY, 32'h8000_0000, 0);

        // zero tolerance: a point on a vertex is not near it
        set_tolerance(8'd0);
        send_beat(OP_QUERY, 0, 32'h7fff_ffff);

        for (k = 0; k < 6; k++) begin
            set_tolerance(tol_plan[k]);
            random_phase(215);
        end

        // overfill the table; the flag must survive a clear
        send_beat(OP_CLEAR, 0, 0);
        for (k = 0; k < MAX_VERTICES + 3; k++)
            send_beat(OP_APPEND, pick_coord(20), pick_coord(20));
        for (k = 0; k < 6; k++)
            send_beat(OP_QUERY, pick_coord(20), pick_coord(20));
        send_beat(OP_CLEAR, 0, 0);
        send_beat(OP_QUERY, 0, 0);
        random_phase(60);

        // drain, then let the core settle
        s_valid <= 1'b0;
        while (tracker.answers.size() != 0) @(posedge aclk);
        repeat (MAX_VERTICES + 20) @(posedge aclk);
        if (tracker.errors == 0)
            $display("point_in_polygon_test_core_tb: done, clean");
        else
            $display("point_in_polygon_test_core_tb: done, errors");
        $finish;
    end

endmodule
